/* src/sra_pkg.sv */
`default_nettype none

package sra_pkg;

  localparam int SLOT_COUNT_DEF  = 16;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int CMD_W   = 4;
  localparam int FIELD_W = 4;
  localparam int WORD_W  = 32;

  localparam logic [CMD_W-1:0] OP_ADD   = 4'd0;
  localparam logic [CMD_W-1:0] OP_SUB   = 4'd1;
  localparam logic [CMD_W-1:0] OP_MUL   = 4'd2;
  localparam logic [CMD_W-1:0] OP_DIV   = 4'd3;
  localparam logic [CMD_W-1:0] OP_MOD   = 4'd4;
  localparam logic [CMD_W-1:0] OP_AND   = 4'd5;
  localparam logic [CMD_W-1:0] OP_OR    = 4'd6;
  localparam logic [CMD_W-1:0] OP_XOR   = 4'd7;
  localparam logic [CMD_W-1:0] OP_SHL   = 4'd8;
  localparam logic [CMD_W-1:0] OP_SHR   = 4'd9;
  localparam logic [CMD_W-1:0] OP_WRITE = 4'd10;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef struct packed {
    logic load;
    logic start;
    logic step;
    logic commit;
  } dp_cmd_t;

endpackage

`default_nettype wire

/* src/sra_ctrl.sv */
`default_nettype none

module sra_ctrl
  import sra_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_stall,
  output logic         out_valid,
  input  wire logic    out_stall,
  input  wire logic    iter_op,
  output dp_cmd_t      dp_cmd
);

  localparam int CNT_W = $clog2(VALUE_WIDTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_RUN,
    S_FIN
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   cnt;

  always_comb begin
    dp_cmd.load   = in_valid && (state == S_IDLE);
    dp_cmd.start  = (state == S_READ) && iter_op;
    dp_cmd.step   = (state == S_RUN);
    dp_cmd.commit = (state == S_FIN) && (!out_valid || !out_stall);
    in_stall      = (state != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          if (iter_op) begin
            cnt   <= CNT_W'(VALUE_WIDTH - 1);
            state <= S_RUN;
          end else begin
            state <= S_FIN;
          end
        end
        S_RUN: begin
          if (cnt == '0) begin
            state <= S_FIN;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      // A finished word waits in the output register until it is taken.
      if (dp_cmd.commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* src/sra_dpath.sv */
`default_nettype none

module sra_dpath
  import sra_pkg::*;
#(
  parameter int SLOT_COUNT  = SLOT_COUNT_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire dp_cmd_t            dp_cmd,
  input  wire logic [CMD_W-1:0]   cmd,
  input  wire logic [FIELD_W-1:0] dest_slot,
  input  wire logic [FIELD_W-1:0] first_source,
  input  wire logic [FIELD_W-1:0] second_source,
  input  wire logic [WORD_W-1:0]  write_value,
  output logic                    iter_op,
  output logic                    status,
  output logic [WORD_W-1:0]       written_value
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int SH_W  = $clog2(VALUE_WIDTH);
  localparam logic [FIELD_W:0] SLOTS = (FIELD_W + 1)'(SLOT_COUNT);

  logic [VALUE_WIDTH-1:0] slot_mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0]  slot_valid;

  logic [CMD_W-1:0]       op;
  logic [FIELD_W-1:0]     dest;
  logic [WORD_W-1:0]      wval;
  logic [VALUE_WIDTH-1:0] rd_a;
  logic [VALUE_WIDTH-1:0] rd_b;
  logic                   a_ok;
  logic                   b_ok;

  logic [VALUE_WIDTH-1:0] x;
  logic [VALUE_WIDTH-1:0] y;
  logic [VALUE_WIDTH-1:0] z;

  logic                   src1_in;
  logic                   src2_in;
  logic                   dest_in;
  logic [VALUE_WIDTH-1:0] a;
  logic [VALUE_WIDTH-1:0] b;
  logic                   is_mul;
  logic                   bad_op;
  logic                   big_shift;
  logic [VALUE_WIDTH-1:0] result;
  logic [VALUE_WIDTH:0]   rem_sh;
  logic [VALUE_WIDTH:0]   rem_diff;
  logic [VALUE_WIDTH-1:0] x_next;
  logic [VALUE_WIDTH-1:0] y_next;
  logic [VALUE_WIDTH-1:0] z_next;

  always_comb begin
    src1_in   = {1'b0, first_source} < SLOTS;
    src2_in   = {1'b0, second_source} < SLOTS;
    dest_in   = {1'b0, dest} < SLOTS;
    a         = a_ok ? rd_a : '0;
    b         = b_ok ? rd_b : '0;
    is_mul    = (op == OP_MUL);
    iter_op   = op inside {OP_MUL, OP_DIV, OP_MOD};
    bad_op    = !(op inside {[OP_ADD:OP_WRITE]});
    big_shift = b >= VALUE_WIDTH'(VALUE_WIDTH);

    case (op)
      OP_ADD:   result = a + b;
      OP_SUB:   result = a - b;
      OP_MUL:   result = z;
      OP_DIV:   result = y;
      OP_MOD:   result = z;
      OP_AND:   result = a & b;
      OP_OR:    result = a | b;
      OP_XOR:   result = a ^ b;
      OP_SHL:   result = big_shift ? '0 : (a << b[SH_W-1:0]);
      OP_SHR:   result = big_shift ? '0 : (a >> b[SH_W-1:0]);
      OP_WRITE: result = VALUE_WIDTH'(wval);
      default:  result = '0;
    endcase

    // Shift-add multiply keeps the product in z; restoring division keeps the
    // quotient in y and the remainder in z. A zero divisor yields all ones and
    // leaves the dividend as remainder without any special handling.
    rem_sh   = {z, y[VALUE_WIDTH-1]};
    rem_diff = rem_sh - {1'b0, b};
    if (is_mul) begin
      z_next = z + (y[0] ? x : '0);
      x_next = x << 1;
      y_next = y >> 1;
    end else begin
      x_next = x;
      if (!rem_diff[VALUE_WIDTH]) begin
        z_next = rem_diff[VALUE_WIDTH-1:0];
        y_next = {y[VALUE_WIDTH-2:0], 1'b1};
      end else begin
        z_next = rem_sh[VALUE_WIDTH-1:0];
        y_next = {y[VALUE_WIDTH-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      op   <= cmd;
      dest <= dest_slot;
      wval <= write_value;
      rd_a <= slot_mem[first_source[IDX_W-1:0]];
      rd_b <= slot_mem[second_source[IDX_W-1:0]];
      a_ok <= src1_in && slot_valid[first_source[IDX_W-1:0]];
      b_ok <= src2_in && slot_valid[second_source[IDX_W-1:0]];
    end

    if (dp_cmd.start) begin
      x <= a;
      y <= is_mul ? b : a;
      z <= '0;
    end else if (dp_cmd.step) begin
      x <= x_next;
      y <= y_next;
      z <= z_next;
    end

    if (dp_cmd.commit) begin
      if (!bad_op && dest_in) begin
        slot_mem[dest[IDX_W-1:0]] <= result;
      end
      status        <= bad_op ? STATUS_ERR : STATUS_OK;
      written_value <= (!bad_op && dest_in) ? WORD_W'(result) : '0;
    end
  end

  // Slots that were never written read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (dp_cmd.commit && !bad_op && dest_in) begin
      slot_valid[dest[IDX_W-1:0]] <= 1'b1;
    end
  end

endmodule

`default_nettype wire

/* src/slot_register_alu.sv */
// A word is loaded in S_IDLE, passes S_READ, steps through S_RUN for
// multiply, divide and modulo, which share one bit-serial shift-add/subtract
// unit, and is committed in S_FIN. No new word is taken until the last is
// committed; S_FIN waits while the output register holds an untaken word.
// Reset clears the controller, the output valid and all slot valid bits, so
// every slot reads as zero afterwards; no clearing pass is needed.
`default_nettype none

module slot_register_alu
  import sra_pkg::*;
#(
  parameter int SLOT_COUNT  = SLOT_COUNT_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [CMD_W-1:0]   cmd,
  input  wire logic [FIELD_W-1:0] dest_slot,
  input  wire logic [FIELD_W-1:0] first_source,
  input  wire logic [FIELD_W-1:0] second_source,
  input  wire logic [WORD_W-1:0]  write_value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    status,
  output logic [WORD_W-1:0]       written_value
);

  dp_cmd_t dp_cmd;
  logic    iter_op;

  sra_ctrl #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .iter_op   (iter_op),
    .dp_cmd    (dp_cmd)
  );

  sra_dpath #(
    .SLOT_COUNT (SLOT_COUNT),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .dp_cmd       (dp_cmd),
    .cmd          (cmd),
    .dest_slot    (dest_slot),
    .first_source (first_source),
    .second_source(second_source),
    .write_value  (write_value),
    .iter_op      (iter_op),
    .status       (status),
    .written_value(written_value)
  );

  // Only one word is in flight, so an accepted word must close the input.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a word was still in progress");

  // A result may only land in the output register when it is free.
  a_commit_has_room: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.commit |-> (!out_valid || !out_stall))
    else $error("result committed over an untaken output word");

  a_load_commit_apart: assert property (@(posedge clk) disable iff (rst)
    !(dp_cmd.load && dp_cmd.commit))
    else $error("load and commit in the same cycle");

endmodule

`default_nettype wire
